[hdl/lrup_pkg.sv]
// Shared types and constants for the LRU page replacement block.
// No dependencies; used by lrup_cell and lru_page_replacement_top.
package lrup_pkg;

    localparam int NUM_CELLS = 32;
    localparam int PAGE_W    = 5;
    localparam int FRAME_W   = 5;
    localparam int CNT_W     = 6;
    localparam int FAULT_W   = 16;

    localparam logic [CNT_W-1:0]   MAX_FRAMES   = 6'd32;
    localparam logic [CNT_W-1:0]   MIN_FRAMES   = 6'd1;
    localparam logic [CNT_W-1:0]   RESET_FRAMES = 6'd32;
    localparam logic [FAULT_W-1:0] FAULT_MAX    = '1;

    // One slot of the recency stack
    typedef struct packed {
        logic               valid;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } entry_t;

    // Per-reference control broadcast to every cell
    typedef struct packed {
        logic update;
        logic hit;
        logic evict;
    } cell_ctrl_t;

    // Signals rippling down the row of cells
    typedef struct packed {
        logic               go;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } chain_t;

endpackage

[hdl/lru_page_replacement_top.sv]
// LRU page replacement unit: top level with the row of stack cells.
// Depends on lrup_pkg and lrup_cell.
//
// Usage: one page reference per input transfer (page_number over
// in_valid/in_ready); one result per reference on the output channel
// (hit, frame_number, evicted_valid, evicted_page, fault_count over
// out_valid/out_ready). Resident pages sit in a row of 32 cells ordered
// by recency, most recent in cell 0. A reference is matched in every
// cell at once, and a shift enable ripples down the row so the cells in
// front of the hit or evicted slot move back one place while the page
// enters cell 0. Free frames are handed out in order until the
// configured count is reached; after that the deepest cell is evicted.
// out_valid rises in the cycle after the input transfer, and a new
// reference is taken every cycle unless the output stalls; compare and
// ripple are combinational. The output register frees up as soon as its
// result is taken, so input is accepted while out_ready is high or the
// output register is empty; when the receiver stalls, in_ready drops.
// Reset empties all cells, clears the free-frame and fault counters and
// sets frames_in_use to 32. cfg_write_en writes frames_in_use at once.
module lru_page_replacement_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [lrup_pkg::CNT_W-1:0]       cfg_write_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [lrup_pkg::PAGE_W-1:0]      page_number,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit,
    output logic [lrup_pkg::FRAME_W-1:0]     frame_number,
    output logic                             evicted_valid,
    output logic [lrup_pkg::PAGE_W-1:0]      evicted_page,
    output logic [lrup_pkg::FAULT_W-1:0]     fault_count
);

    logic [lrup_pkg::CNT_W-1:0]    frames_reg;
    logic [lrup_pkg::CNT_W-1:0]    frames_eff;
    logic [lrup_pkg::CNT_W-1:0]    free_reg;
    logic [lrup_pkg::CNT_W-1:0]    free_next;
    logic [lrup_pkg::FAULT_W-1:0]  faults_reg;
    logic [lrup_pkg::FAULT_W-1:0]  faults_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          hit_reg;
    logic [lrup_pkg::FRAME_W-1:0]  frame_reg;
    logic                          ev_valid_reg;
    logic [lrup_pkg::PAGE_W-1:0]   ev_page_reg;

    logic                          accept;
    logic                          hit_any;
    logic                          evict;
    logic [lrup_pkg::FRAME_W-1:0]  new_frame;
    logic [lrup_pkg::NUM_CELLS-1:0] match_vec;

    lrup_pkg::cell_ctrl_t          ctrl;
    lrup_pkg::entry_t              new_entry;
    lrup_pkg::entry_t              entries [lrup_pkg::NUM_CELLS];
    lrup_pkg::chain_t              chain   [lrup_pkg::NUM_CELLS+1];

    // Handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Clamp the configured frame count
    always_comb
    begin
        if (frames_reg == '0)
            frames_eff = lrup_pkg::MIN_FRAMES;
        else if (frames_reg > lrup_pkg::MAX_FRAMES)
            frames_eff = lrup_pkg::MAX_FRAMES;
        else
            frames_eff = frames_reg;
    end

    // Hit or fault, and whether the fault needs a victim
    assign hit_any = |match_vec;
    assign evict   = !hit_any && !(free_reg < frames_eff);

    assign ctrl.update = accept;
    assign ctrl.hit    = hit_any;
    assign ctrl.evict  = evict;

    // Ripple chain head: cell 0 takes the new entry on every accepted reference
    assign chain[0].go    = 1'b1;
    assign chain[0].page  = '0;
    assign chain[0].frame = '0;

    assign new_frame = (hit_any || evict) ? chain[lrup_pkg::NUM_CELLS].frame
                                          : free_reg[lrup_pkg::FRAME_W-1:0];

    assign new_entry.valid = 1'b1;
    assign new_entry.page  = page_number;
    assign new_entry.frame = new_frame;

    // Row of recency cells
    genvar gi;
    generate
        for (gi = 0; gi < lrup_pkg::NUM_CELLS; gi++)
        begin : g_cell
            lrup_pkg::entry_t prev_entry;
            logic             nxt_valid;

            if (gi == 0)
            begin : g_head
                assign prev_entry = new_entry;
            end
            else
            begin : g_body
                assign prev_entry = entries[gi-1];
            end

            if (gi == lrup_pkg::NUM_CELLS-1)
            begin : g_tail
                assign nxt_valid = 1'b0;
            end
            else
            begin : g_mid
                assign nxt_valid = entries[gi+1].valid;
            end

            lrup_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ref_page   (page_number),
                .ctrl       (ctrl),
                .prev       (prev_entry),
                .next_valid (nxt_valid),
                .chain_in   (chain[gi]),
                .chain_out  (chain[gi+1]),
                .entry      (entries[gi]),
                .match      (match_vec[gi])
            );
        end
    endgenerate

    // Free-frame and fault counters
    always_comb
    begin
        free_next   = free_reg;
        faults_next = faults_reg;
        if (accept && !hit_any)
        begin
            if (!evict)
                free_next = free_reg + 1'b1;
            if (faults_reg != lrup_pkg::FAULT_MAX)
                faults_next = faults_reg + 1'b1;
        end
    end

    assign out_valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= lrup_pkg::RESET_FRAMES;
            free_reg      <= '0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                frames_reg <= cfg_write_data;
            free_reg      <= free_next;
            faults_reg    <= faults_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg      <= hit_any;
            frame_reg    <= new_frame;
            ev_valid_reg <= evict;
            ev_page_reg  <= evict ? chain[lrup_pkg::NUM_CELLS].page : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_number  = frame_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_count   = faults_reg;

endmodule

[hdl/lrup_cell.sv]
// One slot of the LRU recency stack: holds a resident page and its frame.
// Depends on lrup_pkg.
module lrup_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [lrup_pkg::PAGE_W-1:0]      ref_page,
    input  lrup_pkg::cell_ctrl_t             ctrl,
    input  lrup_pkg::entry_t                 prev,
    input  logic                             next_valid,
    input  lrup_pkg::chain_t                 chain_in,
    output lrup_pkg::chain_t                 chain_out,
    output lrup_pkg::entry_t                 entry,
    output logic                             match
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [lrup_pkg::PAGE_W-1:0]      page_reg;
    logic [lrup_pkg::PAGE_W-1:0]      page_next;
    logic [lrup_pkg::FRAME_W-1:0]     frame_reg;
    logic [lrup_pkg::FRAME_W-1:0]     frame_next;
    logic                             last;
    logic                             stop;
    logic                             shift;

    assign entry.valid = valid_reg;
    assign entry.page  = page_reg;
    assign entry.frame = frame_reg;

    // Compare against the referenced page; deepest valid slot is the LRU page
    assign match = valid_reg && (page_reg == ref_page);
    assign last  = valid_reg && !next_valid;
    assign stop  = ctrl.hit ? match : (ctrl.evict && last);

    // Pass the shift enable on until the stopping slot; collect its contents
    always_comb
    begin
        chain_out.go    = chain_in.go && !stop;
        chain_out.page  = chain_in.page  | (stop ? page_reg  : '0);
        chain_out.frame = chain_in.frame | (stop ? frame_reg : '0);
    end

    // Take the neighbor's entry when the shift reaches this slot
    assign shift      = ctrl.update && chain_in.go;
    assign valid_next = shift ? prev.valid : valid_reg;
    assign page_next  = shift ? prev.page  : page_reg;
    assign frame_next = shift ? prev.frame : frame_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg  <= page_next;
        frame_reg <= frame_next;
    end

endmodule

[tb/tb_lru_page_replacement_top.sv]
// Self-checking testbench for lru_page_replacement_top: page references with random
// gaps and output stalls, checked against an LRU predictor kept in a scoreboard class.
// Depends on lrup_pkg and lru_page_replacement_top.
module tb_lru_page_replacement_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int SWEEP_REFS     = 30;
    localparam int PHASE_ITEMS    = 100;

    // One lookup result, field by field as on the output ports
    typedef struct packed {
        logic                         hit;
        logic [lrup_pkg::FRAME_W-1:0] frame;
        logic                         evicted_valid;
        logic [lrup_pkg::PAGE_W-1:0]  evicted_page;
        logic [lrup_pkg::FAULT_W-1:0] fault_count;
    } lookup_t;

    // LRU predictor and store of expected lookups
    class lru_page_scoreboard;
        bit                           resident[lrup_pkg::NUM_CELLS];
        logic [lrup_pkg::FRAME_W-1:0] frame_of[lrup_pkg::NUM_CELLS];
        int unsigned                  rank[lrup_pkg::NUM_CELLS];
        int unsigned                  next_free;
        logic [lrup_pkg::FAULT_W-1:0] faults;
        logic [lrup_pkg::CNT_W-1:0]   frames_cfg;
        lookup_t                      expected_lookups[$];
        int                           errors;

        function new();
            for (int i = 0; i < lrup_pkg::NUM_CELLS; i++)
            begin
                resident[i] = 0;
                frame_of[i] = '0;
                rank[i]     = 0;
            end
            next_free  = 0;
            faults     = '0;
            frames_cfg = lrup_pkg::RESET_FRAMES;
            errors     = 0;
        endfunction

        function void write_frames(logic [lrup_pkg::CNT_W-1:0] v);
            frames_cfg = v;
        endfunction

        // Zero acts as one frame, anything above the maximum as the maximum
        function int unsigned usable_frames();
            if (frames_cfg == '0)
                return 1;
            if (frames_cfg > lrup_pkg::MAX_FRAMES)
                return lrup_pkg::MAX_FRAMES;
            return frames_cfg;
        endfunction

        // Move page p to the front; pages more recent than limit age by one
        function void promote(int p, int unsigned limit);
            for (int q = 0; q < lrup_pkg::NUM_CELLS; q++)
                if (resident[q] && q != p && rank[q] < limit)
                    rank[q] = rank[q] + 1;
            rank[p] = 0;
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction

        // Accepted reference: predict its lookup and update the page map
        function void note_reference(logic [lrup_pkg::PAGE_W-1:0] page);
            lookup_t     r;
            int          p;
            int          victim;
            bit          found;
            int unsigned best;
            p = page;
            r = '0;
            if (resident[p])
            begin
                r.hit   = 1'b1;
                r.frame = frame_of[p];
                promote(p, rank[p]);
            end
            else
            begin
                if (faults != lrup_pkg::FAULT_MAX)
                    faults = faults + 1'b1;
                if (next_free < usable_frames())
                begin
                    r.frame   = next_free[lrup_pkg::FRAME_W-1:0];
                    next_free = next_free + 1;
                end
                else
                begin
                    // evict the least recently used resident page
                    found  = 0;
                    best   = 0;
                    victim = 0;
                    for (int q = 0; q < lrup_pkg::NUM_CELLS; q++)
                        if (resident[q] && (!found || rank[q] > best))
                        begin
                            best   = rank[q];
                            victim = q;
                            found  = 1;
                        end
                    if (found)
                    begin
                        r.frame          = frame_of[victim];
                        resident[victim] = 0;
                        rank[victim]     = 0;
                        r.evicted_valid  = 1'b1;
                        r.evicted_page   = victim[lrup_pkg::PAGE_W-1:0];
                    end
                end
                frame_of[p] = r.frame;
                promote(p, 32'hFFFF_FFFF);
                resident[p] = 1;
            end
            r.fault_count = faults;
            expected_lookups.push_back(r);
        endfunction

        // Accepted result: compare with the oldest expectation
        function void check_lookup(lookup_t act);
            lookup_t exp_r;
            if (expected_lookups.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("ERROR: unexpected result hit=%0b frame=%0d ev=%0b/%0d flt=%0d",
                             act.hit, act.frame, act.evicted_valid, act.evicted_page,
                             act.fault_count);
                return;
            end
            exp_r = expected_lookups.pop_front();
            if (act.hit !== exp_r.hit || act.frame !== exp_r.frame ||
                act.evicted_valid !== exp_r.evicted_valid ||
                act.evicted_page !== exp_r.evicted_page ||
                act.fault_count !== exp_r.fault_count)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                begin
                    $display("ERROR: lookup mismatch exp hit=%0b frame=%0d ev=%0b/%0d flt=%0d",
                             exp_r.hit, exp_r.frame, exp_r.evicted_valid,
                             exp_r.evicted_page, exp_r.fault_count);
                    $display("       got                 hit=%0b frame=%0d ev=%0b/%0d flt=%0d",
                             act.hit, act.frame, act.evicted_valid,
                             act.evicted_page, act.fault_count);
                end
            end
        endfunction

        // Anything still waiting at the end is a missing result
        function void check_drained();
            if (expected_lookups.size() != 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("ERROR: %0d expected lookups never arrived",
                             expected_lookups.size());
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_write_en;
    logic [lrup_pkg::CNT_W-1:0]   cfg_write_data;
    logic                         in_valid;
    logic                         in_ready;
    logic [lrup_pkg::PAGE_W-1:0]  page_number;
    logic                         out_valid;
    logic                         out_ready;
    logic                         hit;
    logic [lrup_pkg::FRAME_W-1:0] frame_number;
    logic                         evicted_valid;
    logic [lrup_pkg::PAGE_W-1:0]  evicted_page;
    logic [lrup_pkg::FAULT_W-1:0] fault_count;

    lru_page_scoreboard sb;
    bit                 idle_en;
    int                 quiet_cycles;

    lru_page_replacement_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .page_number    (page_number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .frame_number   (frame_number),
        .evicted_valid  (evicted_valid),
        .evicted_page   (evicted_page),
        .fault_count    (fault_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls unless idling is switched off
    always @(negedge clk)
    begin
        if (idle_en)
            out_ready <= ($urandom_range(0, 99) >= 24);
        else
            out_ready <= 1'b1;
    end

    // Monitor: note input transfers, check output transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_reference(page_number);
            if (out_valid && out_ready)
                sb.check_lookup({hit, frame_number, evicted_valid, evicted_page, fault_count});
        end
    end

    // Watchdog: cycles in a row with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Send one reference; called and returns at a falling edge
    task automatic send_page(input logic [lrup_pkg::PAGE_W-1:0] pg);
        while (idle_en && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        page_number <= pg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write frames_in_use once every outstanding lookup has come back
    task automatic write_frames(input logic [lrup_pkg::CNT_W-1:0] v);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        sb.write_frames(v);
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Random references from a sliding working set, with some scattered pages
    task automatic random_phase(input int count);
        logic [lrup_pkg::PAGE_W-1:0] base;
        int                          ws;
        int                          pick;
        base = '0;
        ws   = 1;
        for (int i = 0; i < count; i++)
        begin
            if (i % 25 == 0)
            begin
                pick = $urandom_range(0, lrup_pkg::NUM_CELLS - 1);
                base = pick[lrup_pkg::PAGE_W-1:0];
                ws   = $urandom_range(1, lrup_pkg::NUM_CELLS);
            end
            if ($urandom_range(0, 9) == 0)
                pick = $urandom_range(0, lrup_pkg::NUM_CELLS - 1);
            else
                pick = base + $urandom_range(0, ws - 1);
            send_page(pick[lrup_pkg::PAGE_W-1:0]);
        end
    endtask

    initial
    begin
        logic [lrup_pkg::CNT_W-1:0] settings[12];
        sb             = new();
        idle_en        = 1'b1;
        quiet_cycles   = 0;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        page_number    = '0;
        out_ready      = 1'b0;
        settings = '{6'd2, 6'd4, 6'd1, 6'd0, 6'd8, 6'd16,
                     6'd3, 6'd32, 6'd31, 6'd63, 6'd33, 6'd5};

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: fills, hits, lowering the frame count, out-of-range counts
        send_page(5'd0);
        send_page(5'd31);
        send_page(5'd0);
        send_page(5'd31);
        send_page(5'd10);
        send_page(5'd21);
        send_page(5'd0);
        write_frames(6'd0);
        send_page(5'd5);
        send_page(5'd5);
        send_page(5'd31);
        write_frames(6'd63);
        send_page(5'd7);
        send_page(5'd7);
        send_page(5'd16);
        write_frames(6'd1);
        send_page(5'd1);
        send_page(5'd2);
        write_frames(6'd33);
        send_page(5'd3);

        // Cyclic sweep over the pages with one frame: pages still resident from
        // before hit, and every fault evicts the least recently used page
        write_frames(6'd1);
        for (int i = 0; i < SWEEP_REFS; i++)
            send_page(i[lrup_pkg::PAGE_W-1:0]);

        // Random phases over a range of frame counts; one phase without idling
        foreach (settings[k])
        begin
            write_frames(settings[k]);
            idle_en = (k != 5);
            random_phase(PHASE_ITEMS);
        end
        idle_en = 1'b1;

        // Drain and finish
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
